// ===== hw/rtl/plane_to_plane_track_extrapolation_assert.svh =====
// Assertion macros for the plane-to-plane track extrapolation block
`ifndef PLANE_TO_PLANE_TRACK_EXTRAPOLATION_ASSERT_SVH
`define PLANE_TO_PLANE_TRACK_EXTRAPOLATION_ASSERT_SVH
`ifndef ASSERT_OFF
`define P2P_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define P2P_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define P2P_ASSERT_IMP(lbl, ante, cons, msg)
`define P2P_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/p2p_pkg.sv =====
// Shared constants, types and helper functions of the track extrapolation block
`default_nettype none
package p2p_pkg;

  localparam int DATA_W          = 32;
  localparam int ROT_W           = 21;
  localparam int ROT_FRAC        = 19;
  localparam int ROT_ROW_W       = 63;
  localparam int F_W             = 55;
  localparam int G_W             = 56;
  localparam int P_W             = 33;
  localparam int FP_W            = 53;
  localparam int GP_W            = 54;
  localparam int HALF_W          = 28;
  localparam int PP_W            = 56;
  localparam int PROD_W          = 112;
  localparam int PN_W            = 113;
  localparam int SLOPE_FRAC      = 28;
  localparam int POS_SHIFT       = 19;
  localparam int NUM_W           = 93;
  localparam int D_W             = F_W;
  localparam int Q_W             = 32;
  localparam int LANES           = 4;
  localparam int DIV_STEPS       = 4;
  localparam int DIV_STEP_STAGES = Q_W / DIV_STEPS;
  localparam int DIV_STAGES      = DIV_STEP_STAGES + 2;
  localparam int FRONT_STAGES    = 7;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = ROT_ROW_W;

  localparam int LANE_SLOPE_U = 0;
  localparam int LANE_SLOPE_V = 1;
  localparam int LANE_POS_U   = 2;
  localparam int LANE_POS_V   = 3;

  localparam logic [ROT_ROW_W-1:0] ROT_ROW0_RST = ROT_ROW_W'(1) << ROT_FRAC;
  localparam logic [ROT_ROW_W-1:0] ROT_ROW1_RST = ROT_ROW_W'(1) << (ROT_W + ROT_FRAC);
  localparam logic [ROT_ROW_W-1:0] ROT_ROW2_RST = ROT_ROW_W'(1) << (2 * ROT_W + ROT_FRAC);

  localparam logic [Q_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [Q_W-1:0] SAT_MIN = 32'h8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROT_ROW0 = 3'd0,
    CFG_ROT_ROW1 = 3'd1,
    CFG_ROT_ROW2 = 3'd2,
    CFG_ORIGIN_U = 3'd3,
    CFG_ORIGIN_V = 3'd4,
    CFG_ORIGIN_W = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0][ROT_ROW_W-1:0] rot;
    logic signed [DATA_W-1:0]  origin_u;
    logic signed [DATA_W-1:0]  origin_v;
    logic signed [DATA_W-1:0]  origin_w;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] slope_u;
    logic signed [DATA_W-1:0] slope_v;
    logic signed [DATA_W-1:0] pos_u;
    logic signed [DATA_W-1:0] pos_v;
    logic signed [DATA_W-1:0] charge_over_momentum;
  } trk_t;

  typedef struct packed {
    logic [LANES-1:0][NUM_W-1:0] num;
    logic [LANES-1:0]            neg;
    logic [D_W-1:0]              d;
    logic                        zero;
    logic [DATA_W-1:0]           qop;
  } div_in_t;

  typedef struct packed {
    logic [LANES-1:0][D_W-1:0] rem;
    logic [LANES-1:0][Q_W-1:0] low;
    logic [LANES-1:0][Q_W-1:0] quo;
    logic [LANES-1:0]          ovf;
    logic [LANES-1:0]          neg;
    logic [D_W-1:0]            d;
    logic                      zero;
    logic [DATA_W-1:0]         qop;
  } div_st_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_slope_u;
    logic signed [DATA_W-1:0] out_slope_v;
    logic signed [DATA_W-1:0] out_pos_u;
    logic signed [DATA_W-1:0] out_pos_v;
    logic signed [DATA_W-1:0] out_charge_over_momentum;
    logic                     no_intersection;
  } res_t;

  // Entry of a packed rotation row, column 0 in the low bits
  function automatic logic signed [ROT_W-1:0] rot_at(input logic [ROT_ROW_W-1:0] row,
                                                      input logic [1:0] col);
    logic signed [ROT_W-1:0] r;
    unique case (col)
      2'd0:    r = row[ROT_W-1:0];
      2'd1:    r = row[2*ROT_W-1:ROT_W];
      2'd2:    r = row[3*ROT_W-1:2*ROT_W];
      default: r = '0;
    endcase
    return r;
  endfunction

  // Reassemble a 56x56 product from its four 28x28 partial products
  function automatic logic [PROD_W-1:0] prod_combine(input logic [PP_W-1:0] hh,
                                                     input logic [PP_W-1:0] hl,
                                                     input logic [PP_W-1:0] lh,
                                                     input logic [PP_W-1:0] ll);
    return (PROD_W'(hh) << (2 * HALF_W)) + ((PROD_W'(hl) + PROD_W'(lh)) << HALF_W)
           + PROD_W'(ll);
  endfunction

  // Four restoring division steps on every lane
  function automatic div_st_t div_step(input div_st_t s);
    div_st_t      r;
    logic [D_W:0] t;
    r = s;
    for (int l = 0; l < LANES; l++) begin
      for (int i = 0; i < DIV_STEPS; i++) begin
        t = {r.rem[l], r.low[l][Q_W-1]};
        r.low[l] = r.low[l] << 1;
        if (t >= {1'b0, r.d}) begin
          r.rem[l] = D_W'(t - {1'b0, r.d});
          r.quo[l] = {r.quo[l][Q_W-2:0], 1'b1};
        end else begin
          r.rem[l] = t[D_W-1:0];
          r.quo[l] = {r.quo[l][Q_W-2:0], 1'b0};
        end
      end
    end
    return r;
  endfunction

  // Apply the sign to a truncated quotient and clamp to the signed 32-bit range
  function automatic logic [Q_W-1:0] sat32(input logic [Q_W-1:0] q, input logic ovf,
                                           input logic neg);
    logic [Q_W-1:0] r;
    if (!neg) begin
      r = (ovf || q > SAT_MAX) ? SAT_MAX : q;
    end else begin
      r = (ovf || q > SAT_MIN) ? SAT_MIN : (~q + Q_W'(1));
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/p2p_if.sv =====
// Valid/ready channel interfaces for track states in and extrapolated states out
`default_nettype none
interface p2p_in_if;
  logic                     valid;
  logic                     ready;
  logic signed [31:0]       slope_u;
  logic signed [31:0]       slope_v;
  logic signed [31:0]       pos_u;
  logic signed [31:0]       pos_v;
  logic signed [31:0]       charge_over_momentum;

  modport source (output valid, slope_u, slope_v, pos_u, pos_v, charge_over_momentum,
                  input ready);
  modport sink (input valid, slope_u, slope_v, pos_u, pos_v, charge_over_momentum,
                output ready);
endinterface

interface p2p_out_if;
  logic                     valid;
  logic                     ready;
  logic signed [31:0]       out_slope_u;
  logic signed [31:0]       out_slope_v;
  logic signed [31:0]       out_pos_u;
  logic signed [31:0]       out_pos_v;
  logic signed [31:0]       out_charge_over_momentum;
  logic                     no_intersection;

  modport source (output valid, out_slope_u, out_slope_v, out_pos_u, out_pos_v,
                  out_charge_over_momentum, no_intersection, input ready);
  modport sink (input valid, out_slope_u, out_slope_v, out_pos_u, out_pos_v,
                out_charge_over_momentum, no_intersection, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/p2p_front.sv =====
// Rotation, step products and numerator forming: seven pipeline stages
`default_nettype none
module p2p_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  p2p_pkg::cfg_t      cfg_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  p2p_pkg::trk_t      trk_i,
  output logic               valid_o,
  input  logic               ready_i,
  output p2p_pkg::div_in_t   div_o
);

  logic [p2p_pkg::FRONT_STAGES-1:0] v_q;
  logic [p2p_pkg::FRONT_STAGES-1:0] en;

  // stage 1: products
  logic signed [p2p_pkg::P_W-1:0]   p_d [3];
  logic signed [p2p_pkg::FP_W-1:0]  fa_d [3], fb_d [3], fa_q [3], fb_q [3];
  logic signed [p2p_pkg::ROT_W-1:0] rc_q [3];
  logic signed [p2p_pkg::GP_W-1:0]  ga_d [3], gb_d [3], gc_d [3];
  logic signed [p2p_pkg::GP_W-1:0]  ga_q [3], gb_q [3], gc_q [3];
  logic [p2p_pkg::DATA_W-1:0]       qop1_q;
  // stage 2: rotated direction and offset
  logic signed [p2p_pkg::F_W-1:0]   f_q [3];
  logic signed [p2p_pkg::G_W-1:0]   g_q [3];
  logic [p2p_pkg::DATA_W-1:0]       qop2_q;
  // stage 3: magnitudes
  logic [p2p_pkg::F_W-1:0]          fm3_q [3];
  logic [p2p_pkg::G_W-1:0]          gm3_q [3];
  logic [2:0]                       fs3_q, gs3_q;
  logic                             zero3_q;
  logic [p2p_pkg::DATA_W-1:0]       qop3_q;
  // stage 4: partial products
  logic [p2p_pkg::PP_W-1:0]         pp_d [2][2][4], pp_q [2][2][4];
  logic [p2p_pkg::F_W-1:0]          fm4_q [3];
  logic [1:0]                       s1_4_q, s2_4_q, sn4_q;
  logic                             fs2_4_q, zero4_q;
  logic [p2p_pkg::DATA_W-1:0]       qop4_q;
  // stage 5: full products
  logic [p2p_pkg::PROD_W-1:0]       m_q [2][2];
  logic [p2p_pkg::F_W-1:0]          fm5_q [3];
  logic [1:0]                       s1_5_q, s2_5_q, sn5_q;
  logic                             fs2_5_q, zero5_q;
  logic [p2p_pkg::DATA_W-1:0]       qop5_q;
  // stage 6: position numerators
  logic [p2p_pkg::PN_W-1:0]         pn_d [2], pn_q [2];
  logic [p2p_pkg::F_W-1:0]          fm6_q [3];
  logic [1:0]                       sn6_q;
  logic                             fs2_6_q, zero6_q;
  logic [p2p_pkg::DATA_W-1:0]       qop6_q;
  // stage 7: divider operands
  p2p_pkg::div_in_t                 div_d, div_q;

  // stall chain: a stage may load when it is empty or its successor loads
  always_comb begin
    en[p2p_pkg::FRONT_STAGES-1] = !v_q[p2p_pkg::FRONT_STAGES-1] || ready_i;
    for (int s = p2p_pkg::FRONT_STAGES - 2; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[p2p_pkg::FRONT_STAGES-1];
  assign div_o   = div_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= valid_i;
      end
      for (int s = 1; s < p2p_pkg::FRONT_STAGES; s++) begin
        if (en[s]) begin
          v_q[s] <= v_q[s-1];
        end
      end
    end
  end

  always_comb begin
    p_d[0] = $signed({trk_i.pos_u[31], trk_i.pos_u})
           - $signed({cfg_i.origin_u[31], cfg_i.origin_u});
    p_d[1] = $signed({trk_i.pos_v[31], trk_i.pos_v})
           - $signed({cfg_i.origin_v[31], cfg_i.origin_v});
    p_d[2] = -$signed({cfg_i.origin_w[31], cfg_i.origin_w});
    for (int k = 0; k < 3; k++) begin
      fa_d[k] = p2p_pkg::rot_at(cfg_i.rot[k], 2'd0) * trk_i.slope_u;
      fb_d[k] = p2p_pkg::rot_at(cfg_i.rot[k], 2'd1) * trk_i.slope_v;
      ga_d[k] = p2p_pkg::rot_at(cfg_i.rot[k], 2'd0) * p_d[0];
      gb_d[k] = p2p_pkg::rot_at(cfg_i.rot[k], 2'd1) * p_d[1];
      gc_d[k] = p2p_pkg::rot_at(cfg_i.rot[k], 2'd2) * p_d[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int k = 0; k < 3; k++) begin
        fa_q[k] <= fa_d[k];
        fb_q[k] <= fb_d[k];
        rc_q[k] <= p2p_pkg::rot_at(cfg_i.rot[k], 2'd2);
        ga_q[k] <= ga_d[k];
        gb_q[k] <= gb_d[k];
        gc_q[k] <= gc_d[k];
      end
      qop1_q <= trk_i.charge_over_momentum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int k = 0; k < 3; k++) begin
        f_q[k] <= p2p_pkg::F_W'(fa_q[k]) + p2p_pkg::F_W'(fb_q[k])
                + (p2p_pkg::F_W'(rc_q[k]) <<< p2p_pkg::SLOPE_FRAC);
        g_q[k] <= p2p_pkg::G_W'(ga_q[k]) + p2p_pkg::G_W'(gb_q[k]) + p2p_pkg::G_W'(gc_q[k]);
      end
      qop2_q <= qop1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int k = 0; k < 3; k++) begin
        fm3_q[k] <= f_q[k][p2p_pkg::F_W-1] ? p2p_pkg::F_W'(-f_q[k]) : p2p_pkg::F_W'(f_q[k]);
        gm3_q[k] <= g_q[k][p2p_pkg::G_W-1] ? p2p_pkg::G_W'(-g_q[k]) : p2p_pkg::G_W'(g_q[k]);
        fs3_q[k] <= f_q[k][p2p_pkg::F_W-1];
        gs3_q[k] <= g_q[k][p2p_pkg::G_W-1];
      end
      zero3_q <= (f_q[2] == '0);
      qop3_q  <= qop2_q;
    end
  end

  // g_k * f_2 and g_2 * f_k as four 28x28 partial products each
  always_comb begin
    logic [p2p_pkg::PP_W-1:0] a, b;
    for (int k = 0; k < 2; k++) begin
      for (int t = 0; t < 2; t++) begin
        a = (t == 0) ? gm3_q[k] : gm3_q[2];
        b = (t == 0) ? {1'b0, fm3_q[2]} : {1'b0, fm3_q[k]};
        pp_d[k][t][0] = a[p2p_pkg::PP_W-1:p2p_pkg::HALF_W] * b[p2p_pkg::PP_W-1:p2p_pkg::HALF_W];
        pp_d[k][t][1] = a[p2p_pkg::PP_W-1:p2p_pkg::HALF_W] * b[p2p_pkg::HALF_W-1:0];
        pp_d[k][t][2] = a[p2p_pkg::HALF_W-1:0] * b[p2p_pkg::PP_W-1:p2p_pkg::HALF_W];
        pp_d[k][t][3] = a[p2p_pkg::HALF_W-1:0] * b[p2p_pkg::HALF_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      pp_q  <= pp_d;
      fm4_q <= fm3_q;
      for (int k = 0; k < 2; k++) begin
        s1_4_q[k] <= gs3_q[k] ^ fs3_q[2];
        s2_4_q[k] <= gs3_q[2] ^ fs3_q[k];
        sn4_q[k]  <= fs3_q[k] ^ fs3_q[2];
      end
      fs2_4_q <= fs3_q[2];
      zero4_q <= zero3_q;
      qop4_q  <= qop3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      for (int k = 0; k < 2; k++) begin
        for (int t = 0; t < 2; t++) begin
          m_q[k][t] <= p2p_pkg::prod_combine(pp_q[k][t][0], pp_q[k][t][1],
                                             pp_q[k][t][2], pp_q[k][t][3]);
        end
      end
      fm5_q   <= fm4_q;
      s1_5_q  <= s1_4_q;
      s2_5_q  <= s2_4_q;
      sn5_q   <= sn4_q;
      fs2_5_q <= fs2_4_q;
      zero5_q <= zero4_q;
      qop5_q  <= qop4_q;
    end
  end

  // signed difference of the two products as one add with carry-in
  always_comb begin
    logic [p2p_pkg::PN_W-1:0] a, b;
    for (int k = 0; k < 2; k++) begin
      a = s1_5_q[k] ? ~{1'b0, m_q[k][0]} : {1'b0, m_q[k][0]};
      b = s2_5_q[k] ? {1'b0, m_q[k][1]} : ~{1'b0, m_q[k][1]};
      pn_d[k] = a + b + p2p_pkg::PN_W'(s1_5_q[k]) + p2p_pkg::PN_W'(!s2_5_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      pn_q    <= pn_d;
      fm6_q   <= fm5_q;
      sn6_q   <= sn5_q;
      fs2_6_q <= fs2_5_q;
      zero6_q <= zero5_q;
      qop6_q  <= qop5_q;
    end
  end

  always_comb begin
    logic                         pneg;
    logic [p2p_pkg::PN_W-1:0]     pmag;
    div_d = '0;
    for (int k = 0; k < 2; k++) begin
      pneg = pn_q[k][p2p_pkg::PN_W-1];
      pmag = pneg ? (~pn_q[k] + p2p_pkg::PN_W'(1)) : pn_q[k];
      div_d.num[k] = p2p_pkg::NUM_W'(fm6_q[k]) << p2p_pkg::SLOPE_FRAC;
      div_d.neg[k] = sn6_q[k];
      div_d.num[k+2] = pmag[p2p_pkg::PROD_W-1:p2p_pkg::POS_SHIFT];
      div_d.neg[k+2] = pneg ^ fs2_6_q;
    end
    div_d.d    = fm6_q[2];
    div_d.zero = zero6_q;
    div_d.qop  = qop6_q;
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      div_q <= div_d;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/p2p_div.sv =====
// Four-lane pipelined restoring divider with sign, saturation and result register
`default_nettype none
module p2p_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  p2p_pkg::div_in_t   div_i,
  output logic               valid_o,
  input  logic               ready_i,
  output p2p_pkg::res_t      res_o
);

  logic [p2p_pkg::DIV_STAGES-1:0] v_q;
  logic [p2p_pkg::DIV_STAGES-1:0] en;
  p2p_pkg::div_st_t               init_d;
  p2p_pkg::div_st_t               st_q [p2p_pkg::DIV_STEP_STAGES+1];
  p2p_pkg::res_t                  res_d, res_q;

  always_comb begin
    en[p2p_pkg::DIV_STAGES-1] = !v_q[p2p_pkg::DIV_STAGES-1] || ready_i;
    for (int s = p2p_pkg::DIV_STAGES - 2; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[p2p_pkg::DIV_STAGES-1];
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= valid_i;
      end
      for (int s = 1; s < p2p_pkg::DIV_STAGES; s++) begin
        if (en[s]) begin
          v_q[s] <= v_q[s-1];
        end
      end
    end
  end

  // overflow when the quotient needs more than 32 bits; else the high part seeds the remainder
  always_comb begin
    init_d = '0;
    for (int l = 0; l < p2p_pkg::LANES; l++) begin
      init_d.ovf[l] = div_i.num[l][p2p_pkg::NUM_W-1:p2p_pkg::Q_W]
                      >= (p2p_pkg::NUM_W - p2p_pkg::Q_W)'(div_i.d);
      init_d.rem[l] = div_i.num[l][p2p_pkg::D_W+p2p_pkg::Q_W-1:p2p_pkg::Q_W];
      init_d.low[l] = div_i.num[l][p2p_pkg::Q_W-1:0];
    end
    init_d.neg  = div_i.neg;
    init_d.d    = div_i.d;
    init_d.zero = div_i.zero;
    init_d.qop  = div_i.qop;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      st_q[0] <= init_d;
    end
  end

  for (genvar s = 1; s <= p2p_pkg::DIV_STEP_STAGES; s++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en[s]) begin
        st_q[s] <= p2p_pkg::div_step(st_q[s-1]);
      end
    end
  end

  always_comb begin
    p2p_pkg::div_st_t l;
    l = st_q[p2p_pkg::DIV_STEP_STAGES];
    if (l.zero) begin
      res_d = '0;
      res_d.no_intersection = 1'b1;
    end else begin
      res_d.out_slope_u = p2p_pkg::sat32(l.quo[p2p_pkg::LANE_SLOPE_U],
                                         l.ovf[p2p_pkg::LANE_SLOPE_U],
                                         l.neg[p2p_pkg::LANE_SLOPE_U]);
      res_d.out_slope_v = p2p_pkg::sat32(l.quo[p2p_pkg::LANE_SLOPE_V],
                                         l.ovf[p2p_pkg::LANE_SLOPE_V],
                                         l.neg[p2p_pkg::LANE_SLOPE_V]);
      res_d.out_pos_u   = p2p_pkg::sat32(l.quo[p2p_pkg::LANE_POS_U],
                                         l.ovf[p2p_pkg::LANE_POS_U],
                                         l.neg[p2p_pkg::LANE_POS_U]);
      res_d.out_pos_v   = p2p_pkg::sat32(l.quo[p2p_pkg::LANE_POS_V],
                                         l.ovf[p2p_pkg::LANE_POS_V],
                                         l.neg[p2p_pkg::LANE_POS_V]);
      res_d.out_charge_over_momentum = l.qop;
      res_d.no_intersection = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[p2p_pkg::DIV_STAGES-1]) begin
      res_q <= res_d;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/plane_to_plane_track_extrapolation.sv =====
// Top level: configuration registers, arithmetic front end and divider pipeline
// Pipeline: 17 register stages (7 front-end, 10 divider), the last of them the result
//   register that holds each result for its output transfer.
// Throughput: one track per cycle while the output does not stall; the 32 quotient bits come
//   from 8 divider stages of 4 restoring steps each, the four numerators divided in parallel lanes.
// Stalls back up stage by stage, so empty stages still take new tracks while a result waits.
// Reset clears all valid bits, loads the identity rotation and a zero origin.
`default_nettype none
`include "plane_to_plane_track_extrapolation_assert.svh"
module plane_to_plane_track_extrapolation (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  p2p_in_if.sink                            trk_in,
  p2p_out_if.source                         trk_out,
  input  logic                              cfg_we_i,
  input  logic [p2p_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [p2p_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  p2p_pkg::cfg_t    cfg_q;
  p2p_pkg::trk_t    trk;
  p2p_pkg::div_in_t div_op;
  p2p_pkg::res_t    res;
  logic             div_valid;
  logic             div_ready;

  // Configuration: the user must write it only while the pipeline is drained, so no shadowing
  // is needed; the block itself does not enforce this. Unknown register indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rot[0]   <= p2p_pkg::ROT_ROW0_RST;
      cfg_q.rot[1]   <= p2p_pkg::ROT_ROW1_RST;
      cfg_q.rot[2]   <= p2p_pkg::ROT_ROW2_RST;
      cfg_q.origin_u <= '0;
      cfg_q.origin_v <= '0;
      cfg_q.origin_w <= '0;
    end else if (cfg_we_i) begin
      unique case (p2p_pkg::cfg_reg_e'(cfg_idx_i))
        p2p_pkg::CFG_ROT_ROW0: cfg_q.rot[0]   <= cfg_wdata_i;
        p2p_pkg::CFG_ROT_ROW1: cfg_q.rot[1]   <= cfg_wdata_i;
        p2p_pkg::CFG_ROT_ROW2: cfg_q.rot[2]   <= cfg_wdata_i;
        p2p_pkg::CFG_ORIGIN_U: cfg_q.origin_u <= cfg_wdata_i[p2p_pkg::DATA_W-1:0];
        p2p_pkg::CFG_ORIGIN_V: cfg_q.origin_v <= cfg_wdata_i[p2p_pkg::DATA_W-1:0];
        p2p_pkg::CFG_ORIGIN_W: cfg_q.origin_w <= cfg_wdata_i[p2p_pkg::DATA_W-1:0];
        default: ;
      endcase
    end
  end

  assign trk.slope_u              = trk_in.slope_u;
  assign trk.slope_v              = trk_in.slope_v;
  assign trk.pos_u                = trk_in.pos_u;
  assign trk.pos_v                = trk_in.pos_v;
  assign trk.charge_over_momentum = trk_in.charge_over_momentum;

  // Front end: rotate direction and offset, form the slope and position numerators
  p2p_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (trk_in.valid),
    .ready_o (trk_in.ready),
    .trk_i   (trk),
    .valid_o (div_valid),
    .ready_i (div_ready),
    .div_o   (div_op)
  );

  // Divider: divide all four numerators by |F_2|, sign, saturate, hold result for transfer
  p2p_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_valid),
    .ready_o (div_ready),
    .div_i   (div_op),
    .valid_o (trk_out.valid),
    .ready_i (trk_out.ready),
    .res_o   (res)
  );

  assign trk_out.out_slope_u              = res.out_slope_u;
  assign trk_out.out_slope_v              = res.out_slope_v;
  assign trk_out.out_pos_u                = res.out_pos_u;
  assign trk_out.out_pos_v                = res.out_pos_v;
  assign trk_out.out_charge_over_momentum = res.out_charge_over_momentum;
  assign trk_out.no_intersection          = res.no_intersection;

  // A parallel track must come out as an all-zero state
  `P2P_ASSERT_IMP(a_parallel_zero, trk_out.valid && trk_out.no_intersection, trk_out.out_slope_u == '0 && trk_out.out_pos_v == '0 && trk_out.out_charge_over_momentum == '0, "parallel track result not cleared")
  // With the result register empty the whole pipeline can advance
  `P2P_ASSERT_IMP(a_ready_when_empty, !trk_out.valid, trk_in.ready, "input stalled with empty output")
  // A rotation row write lands in the register the next cycle
  `P2P_ASSERT_NXT(a_cfg_row0, rst_ni && cfg_we_i && cfg_idx_i == p2p_pkg::CFG_ROT_ROW0, cfg_q.rot[0] == $past(cfg_wdata_i), "rotation row 0 write lost")

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the plane-to-plane straight-line track extrapolator
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import p2p_pkg::*;

  localparam int FLUSH_CYCLES = 40;      // comfortably past the pipeline depth
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;     // long receiver hold-off, fills the pipeline

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  cfg_reg_e cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  p2p_in_if  trk_in_ch ();
  p2p_out_if trk_out_ch ();

  plane_to_plane_track_extrapolation dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .trk_in      (trk_in_ch),
    .trk_out     (trk_out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // Shadow of the configuration registers, as the block should hold them
  logic [ROT_ROW_W-1:0] rot_shadow [3];
  logic [DATA_W-1:0]    org_shadow [3];

  trk_t tracks_pending [$];   // tracks waiting to be offered
  res_t states_expected [$];  // extrapolated states still to come out
  logic took;                 // an input transfer happened at the last rising edge
  int   accepted_cnt;
  int   cycle_cnt;
  int   burst_left;
  int   gap_left;
  int   err_cnt;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Sign the truncated quotient and clamp it onto the 32-bit signed range
  function automatic logic [31:0] clamp_quotient(logic [127:0] q, logic neg);
    if (!neg) return (q > 128'h7FFF_FFFF) ? SAT_MAX : q[31:0];
    return (q > 128'h8000_0000) ? SAT_MIN : (~q[31:0] + 32'd1);
  endfunction

  // Rotate the direction, intersect with the target plane, saturate
  function automatic res_t extrapolate(trk_t t);
    logic signed [127:0] f [3];
    logic signed [127:0] g [3];
    logic signed [127:0] p [3];
    logic signed [127:0] e [3];
    logic signed [127:0] pn;
    logic signed [20:0]  r;
    logic [127:0]        d;
    logic [127:0]        num;
    logic [31:0]         slope_o [2];
    logic [31:0]         pos_o [2];
    res_t                o;
    p[0] = $signed(t.pos_u) - $signed(org_shadow[0]);
    p[1] = $signed(t.pos_v) - $signed(org_shadow[1]);
    p[2] = -$signed(org_shadow[2]);
    for (int k = 0; k < 3; k++) begin
      for (int c = 0; c < 3; c++) begin
        r = rot_shadow[k][ROT_W*c +: ROT_W];
        e[c] = r;
      end
      f[k] = e[0] * $signed(t.slope_u) + e[1] * $signed(t.slope_v) + (e[2] <<< SLOPE_FRAC);
      g[k] = e[0] * p[0] + e[1] * p[1] + e[2] * p[2];
    end
    o = '0;
    if (f[2] == 0) begin
      // track runs parallel to the target plane
      o.no_intersection = 1'b1;
      return o;
    end
    d = (f[2] < 0) ? -f[2] : f[2];
    for (int k = 0; k < 2; k++) begin
      num = (f[k] < 0) ? -f[k] : f[k];
      slope_o[k] = clamp_quotient((num << SLOPE_FRAC) / d, (f[k] < 0) != (f[2] < 0));
      pn = g[k] * f[2] - g[2] * f[k];
      num = (pn < 0) ? -pn : pn;
      pos_o[k] = clamp_quotient((num >> POS_SHIFT) / d, (pn < 0) != (f[2] < 0));
    end
    o.out_slope_u = slope_o[0];
    o.out_slope_v = slope_o[1];
    o.out_pos_u = pos_o[0];
    o.out_pos_v = pos_o[1];
    o.out_charge_over_momentum = t.charge_over_momentum;
    return o;
  endfunction

  // Mix of full-range, small, extreme and zero values
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0, 1:    return $urandom();
      2:       return 32'($signed($urandom_range(0, 2097151)) - 1048576);
      3:       return $urandom_range(0, 1) ? SAT_MAX : SAT_MIN;
      4:       return 32'($signed($urandom_range(0, 511)) - 256) << 16;
      default: return '0;
    endcase
  endfunction

  function automatic logic [ROT_W-1:0] pick_rot_entry();
    case ($urandom_range(0, 4))
      0:       return ROT_W'($urandom());
      1:       return $urandom_range(0, 1) ? 21'h08_0000 : 21'h18_0000;  // +1.0 / -1.0
      2:       return 21'($signed($urandom_range(0, 1048575)) - 524288);
      3:       return $urandom_range(0, 1) ? 21'h0F_FFFF : 21'h10_0000;
      default: return '0;
    endcase
  endfunction

  function automatic trk_t pick_track();
    trk_t t;
    t.slope_u = pick_word();
    t.slope_v = pick_word();
    t.pos_u = pick_word();
    t.pos_v = pick_word();
    t.charge_over_momentum = $urandom();
    return t;
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx <= CFG_ROT_ROW2) rot_shadow[idx] = val[ROT_ROW_W-1:0];
    else org_shadow[idx - CFG_ORIGIN_U] = val[DATA_W-1:0];
  endtask

  task automatic push_track(logic [31:0] su, logic [31:0] sv, logic [31:0] pu,
                            logic [31:0] pv, logic [31:0] qop);
    trk_t t;
    t.slope_u = su;
    t.slope_v = sv;
    t.pos_u = pu;
    t.pos_v = pv;
    t.charge_over_momentum = qop;
    tracks_pending.push_back(t);
  endtask

  task automatic drain();
    while (tracks_pending.size() != 0 || states_expected.size() != 0) @(posedge clk_i);
    repeat (FLUSH_CYCLES) @(posedge clk_i);
  endtask

  task automatic check_word(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // Monitor: compare each output transfer against the oldest expected state
  always @(posedge clk_i) begin
    res_t want;
    if (trk_out_ch.valid && trk_out_ch.ready) begin
      if (states_expected.size() == 0) begin
        $error("unexpected output transfer");
        err_cnt++;
      end else begin
        want = states_expected.pop_front();
        check_word("out_slope_u", want.out_slope_u, trk_out_ch.out_slope_u);
        check_word("out_slope_v", want.out_slope_v, trk_out_ch.out_slope_v);
        check_word("out_pos_u", want.out_pos_u, trk_out_ch.out_pos_u);
        check_word("out_pos_v", want.out_pos_v, trk_out_ch.out_pos_v);
        check_word("out_charge_over_momentum", want.out_charge_over_momentum,
                   trk_out_ch.out_charge_over_momentum);
        check_word("no_intersection", 32'(want.no_intersection),
                   32'(trk_out_ch.no_intersection));
      end
    end
  end

  // Input side: record each transfer, predict its result, retire it from the queue
  always @(posedge clk_i) begin
    trk_t t;
    took <= trk_in_ch.valid && trk_in_ch.ready;
    if (trk_in_ch.valid && trk_in_ch.ready) begin
      t.slope_u = trk_in_ch.slope_u;
      t.slope_v = trk_in_ch.slope_v;
      t.pos_u = trk_in_ch.pos_u;
      t.pos_v = trk_in_ch.pos_v;
      t.charge_over_momentum = trk_in_ch.charge_over_momentum;
      states_expected.push_back(extrapolate(t));
      void'(tracks_pending.pop_front());
      accepted_cnt++;
    end
  end

  // Driver: bursts of random length with random gaps; hold an offered track until taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      trk_in_ch.valid <= 1'b0;
    end else if (trk_in_ch.valid && !took) begin
      // hold: the offered track has not been taken yet
    end else if (gap_left > 0) begin
      trk_in_ch.valid <= 1'b0;
      gap_left--;
    end else if (tracks_pending.size() != 0) begin
      trk_in_ch.valid <= 1'b1;
      trk_in_ch.slope_u <= tracks_pending[0].slope_u;
      trk_in_ch.slope_v <= tracks_pending[0].slope_v;
      trk_in_ch.pos_u <= tracks_pending[0].pos_u;
      trk_in_ch.pos_v <= tracks_pending[0].pos_v;
      trk_in_ch.charge_over_momentum <= tracks_pending[0].charge_over_momentum;
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 40);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      end
    end else begin
      trk_in_ch.valid <= 1'b0;
    end
  end

  // Receiver: random stall pattern re-picked periodically from the cycle counter, plus one long hold-off
  always @(negedge clk_i) begin
    int hold_left;
    int stall_mode;
    bit held_once;
    if (!rst_ni) begin
      trk_out_ch.ready <= 1'b0;
    end else begin
      if (!held_once && accepted_cnt > 400) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (cycle_cnt % 64 == 0) stall_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        trk_out_ch.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0:       trk_out_ch.ready <= 1'b1;
          1:       trk_out_ch.ready <= $urandom_range(0, 1);
          2:       trk_out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: trk_out_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("plane_to_plane_track_extrapolation regression: fail");
      $finish;
    end
  end

  initial begin
    logic [ROT_ROW_W-1:0] row;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_ROT_ROW0;
    cfg_wdata = '0;
    trk_in_ch.valid = 1'b0;
    trk_in_ch.slope_u = '0;
    trk_in_ch.slope_v = '0;
    trk_in_ch.pos_u = '0;
    trk_in_ch.pos_v = '0;
    trk_in_ch.charge_over_momentum = '0;
    trk_out_ch.ready = 1'b0;
    took = 1'b0;
    accepted_cnt = 0;
    cycle_cnt = 0;
    burst_left = 0;
    gap_left = 0;
    err_cnt = 0;
    rot_shadow[0] = ROT_ROW0_RST;
    rot_shadow[1] = ROT_ROW1_RST;
    rot_shadow[2] = ROT_ROW2_RST;
    for (int i = 0; i < 3; i++) org_shadow[i] = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed tracks on the reset identity frame: field extremes and bit patterns
    push_track('0, '0, '0, '0, '0);
    push_track(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX);
    push_track(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN);
    push_track(SAT_MAX, SAT_MIN, SAT_MIN, SAT_MAX, 32'hFFFF_FFFF);
    push_track(32'h1000_0000, 32'hF000_0000, 32'h0001_0000, 32'hFFFF_0000, 32'd1);
    push_track(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    push_track(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    push_track(32'd1, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'h8000_0001);
    drain();

    // Tilted target: only column 0 in row 2, so zero slope_u means a parallel track
    write_reg(CFG_ROT_ROW2, CFG_DATA_W'(21'h08_0000));
    write_reg(CFG_ORIGIN_W, CFG_DATA_W'(32'h0010_0000));
    push_track('0, 32'h1234_5678, 32'd5, 32'd7, 32'h0BAD_F00D);
    push_track('0, SAT_MIN, SAT_MAX, SAT_MIN, 32'h1);
    push_track(32'd1, '0, SAT_MAX, SAT_MAX, 32'h2);
    push_track(SAT_MIN, SAT_MAX, '0, '0, 32'h3);
    drain();

    // Tiny normal component: slopes and positions saturate both ways
    write_reg(CFG_ROT_ROW2, CFG_DATA_W'(21'd1) << (2 * ROT_W));
    push_track(SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN, 32'h4);
    push_track(32'h0000_0100, 32'hFFFF_FF00, 32'h4000_0000, 32'hC000_0000, 32'h5);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      // Each phase writes every register; phases 1 and 2 pin the extremes
      for (int k = 0; k < 3; k++) begin
        case (phase)
          1:       row = '1;
          2:       row = (k == 2) ? '0 : {ROT_ROW_W{1'b0}} | (63'h10_0000 << (ROT_W * k));
          default: row = {pick_rot_entry(), pick_rot_entry(), pick_rot_entry()};
        endcase
        if (phase == 0) row = (k == 0) ? ROT_ROW0_RST : (k == 1) ? ROT_ROW1_RST : ROT_ROW2_RST;
        if (phase == 3 && k == 2) row = {21'd0, 21'd0, pick_rot_entry()};
        write_reg(cfg_reg_e'(k), row);
      end
      for (int k = 0; k < 3; k++) begin
        case (phase)
          1:       write_reg(cfg_reg_e'(CFG_ORIGIN_U + k), CFG_DATA_W'(SAT_MAX));
          2:       write_reg(cfg_reg_e'(CFG_ORIGIN_U + k), CFG_DATA_W'(SAT_MIN));
          default: write_reg(cfg_reg_e'(CFG_ORIGIN_U + k), CFG_DATA_W'(pick_word()));
        endcase
      end
      for (int n = 0; n < 230; n++) tracks_pending.push_back(pick_track());
      drain();
    end

    if (err_cnt == 0) begin
      $display("plane_to_plane_track_extrapolation regression: pass");
    end else begin
      $display("plane_to_plane_track_extrapolation regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
